/* src/cpt_pkg.sv */
// Shared widths, codes and types for the closest-point-on-triangle block.
// No dependencies; compiled first.
package cpt_pkg;

  localparam int CW  = 32;   // coordinate width, Q16.16
  localparam int DW  = CW + 1;  // difference of two coordinates
  localparam int PW  = 2 * DW;  // one coordinate product
  localparam int TW  = PW + 2;  // sum of three products
  localparam int VW  = 138;  // barycentric terms and determinant
  localparam int KCH = 28;   // chunk width of the wide multiplier operand
  localparam int NK  = 5;    // chunks per wide operand
  localparam int KW  = KCH * NK;
  localparam int NW  = 172;  // numerator and remainder width
  localparam int QB  = 35;   // quotient bits kept before saturation
  localparam int QDEPTH = 4;  // queue depth, a power of two
  localparam int QAW = $clog2(QDEPTH);

  // Gram determinant below 1e-5 in real units counts as degenerate.
  localparam logic signed [VW-1:0] DEGEN_LIMIT = VW'(48'd184467440737096);

  typedef enum logic [2:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_C   = 3'd2,
    REG_AB  = 3'd3,
    REG_AC  = 3'd4,
    REG_BC  = 3'd5,
    REG_IN  = 3'd6,
    REG_DEG = 3'd7
  } region_t;

  // One classified request: either a point to pass on, or a base point
  // plus (m1*k1 + m2*k2) / den to be added to it.
  typedef struct packed {
    logic                    pass;
    region_t                 region;
    logic [2:0][CW-1:0]      pt;
    logic [2:0][DW-1:0]      m1;
    logic [2:0][DW-1:0]      m2;
    logic [VW-1:0]           k1;
    logic [VW-1:0]           k2;
    logic [VW-1:0]           den;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/cpt_if.sv */
// Request and response channel interfaces of the closest-point block.
// Depends on cpt_pkg for the region code type.
interface cpt_req_if;
  logic valid;
  logic ready;
  logic signed [31:0] a_x, a_y, a_z;
  logic signed [31:0] b_x, b_y, b_z;
  logic signed [31:0] c_x, c_y, c_z;
  logic signed [31:0] p_x, p_y, p_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  p_x, p_y, p_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                p_x, p_y, p_z, output ready);
endinterface

interface cpt_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] near_x, near_y, near_z;
  cpt_pkg::region_t region;

  modport source (output valid, near_x, near_y, near_z, region, input ready);
  modport sink (input valid, near_x, near_y, near_z, region, output ready);
endinterface

/* src/cpt_queue.sv */
// Short job queue between the classifying front end and the arithmetic back end.
// Depends on cpt_pkg for the job and control types.
module cpt_queue (
  input  logic            clk,
  input  logic            rst,
  input  cpt_pkg::q_ctl_t ctl,
  input  cpt_pkg::job_t   wdata,
  output cpt_pkg::job_t   rdata,
  output cpt_pkg::q_stat_t stat
);
  import cpt_pkg::*;

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) wr_ptr <= wr_ptr + 1'b1;
      if (ctl.pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(ctl.push) - (QAW+1)'(ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[wr_ptr] <= wdata;
  end

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !stat.full) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !stat.empty) else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + (QAW+1)'($past(ctl.push))
                      - (QAW+1)'($past(ctl.pop)))
    else $error("queue fill count out of step");

endmodule

/* src/cpt_front.sv */
// Front end: takes requests, forms dot products and barycentric terms,
// picks the region and emits one job for the back end. Depends on cpt_pkg.
module cpt_front (
  input  logic             clk,
  input  logic             rst,
  cpt_req_if.sink          req,
  input  cpt_pkg::q_stat_t qstat,
  output logic             push,
  output cpt_pkg::job_t    job
);
  import cpt_pkg::*;

  localparam int HW = TW / 2;
  localparam int D1 = 0, D2 = 1, D3 = 2, D4 = 3, D5 = 4, D6 = 5;
  localparam int EAB = 6, EAC = 7, EBC = 8;

  typedef struct packed {
    logic [2:0][CW-1:0] a, b, c;
    logic [2:0][DW-1:0] ab, ac, bc;
  } geo_t;

  typedef struct packed {
    logic signed [2*HW-1:0] hh;
    logic signed [2*HW:0]   hl;
    logic signed [2*HW:0]   lh;
    logic signed [2*HW+1:0] ll;
  } pp_t;

  typedef struct packed {
    logic ca, cb, cab, cc, cac, cbc;
    logic lo_ab, hi_ab, lo_ac, hi_ac, lo_bc, hi_bc;
  } fl_t;

  function automatic pp_t split_mul(logic signed [TW-1:0] x, logic signed [TW-1:0] y);
    logic signed [HW-1:0] xh, yh;
    logic signed [HW:0]   xl, yl;
    pp_t r;
    xh = x[TW-1:HW];
    yh = y[TW-1:HW];
    xl = {1'b0, x[HW-1:0]};
    yl = {1'b0, y[HW-1:0]};
    r.hh = xh * yh;
    r.hl = xh * yl;
    r.lh = xl * yh;
    r.ll = xl * yl;
    return r;
  endfunction

  function automatic logic signed [VW-1:0] sum_pp(pp_t p);
    return (VW'($signed(p.hh)) <<< (2 * HW))
         + ((VW'($signed(p.hl)) + VW'($signed(p.lh))) <<< HW)
         + VW'($signed(p.ll));
  endfunction

  function automatic job_t seg_job(logic [2:0][CW-1:0] s, logic [2:0][CW-1:0] e,
                                   logic [2:0][DW-1:0] se, logic signed [TW-1:0] num,
                                   logic signed [TW-1:0] den, logic lo, logic hi,
                                   region_t r);
    job_t j;
    j        = '0;
    j.region = r;
    j.pt     = s;
    if (lo) begin
      j.pass = 1'b1;
    end else if (hi) begin
      j.pass = 1'b1;
      j.pt   = e;
    end else begin
      j.pass = 1'b0;
      j.m1   = se;
      j.k1   = VW'(num);
      j.den  = VW'(den);
    end
    return j;
  endfunction

  logic [8:1] vld;
  logic       adv;

  assign adv       = !vld[8] || !qstat.full;
  assign req.ready = adv;
  assign push      = vld[8] && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:1], req.valid};
    end
  end

  logic signed [CW-1:0] ia [3], ib [3], ic [3], ip [3];
  assign ia[0] = req.a_x;
  assign ia[1] = req.a_y;
  assign ia[2] = req.a_z;
  assign ib[0] = req.b_x;
  assign ib[1] = req.b_y;
  assign ib[2] = req.b_z;
  assign ic[0] = req.c_x;
  assign ic[1] = req.c_y;
  assign ic[2] = req.c_z;
  assign ip[0] = req.p_x;
  assign ip[1] = req.p_y;
  assign ip[2] = req.p_z;

  geo_t g1, g2, g3, g4, g5, g6, g7;
  logic signed [DW-1:0] ab1 [3], ac1 [3], bc1 [3], ap1 [3], bp1 [3], cp1 [3];
  logic signed [PW-1:0] pr2 [9][3];
  logic signed [TW-1:0] dt3 [9], dt4 [9], dt5 [9], dt6 [9], dt7 [9];
  logic signed [TW-1:0] nbc4, nbc5, nbc6, nbc7;
  pp_t                  pp4 [6];
  logic signed [VW-1:0] pw5 [6];
  logic signed [VW-1:0] va6, vb6, vc6, vb7, vc7, den7;
  fl_t                  fl7;
  job_t                 job_next;

  // Edge and corner-to-point differences.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ab1[i]   <= DW'(ib[i]) - DW'(ia[i]);
        ac1[i]   <= DW'(ic[i]) - DW'(ia[i]);
        bc1[i]   <= DW'(ic[i]) - DW'(ib[i]);
        ap1[i]   <= DW'(ip[i]) - DW'(ia[i]);
        bp1[i]   <= DW'(ip[i]) - DW'(ib[i]);
        cp1[i]   <= DW'(ip[i]) - DW'(ic[i]);
        g1.a[i]  <= ia[i];
        g1.b[i]  <= ib[i];
        g1.c[i]  <= ic[i];
        g1.ab[i] <= DW'(ib[i]) - DW'(ia[i]);
        g1.ac[i] <= DW'(ic[i]) - DW'(ia[i]);
        g1.bc[i] <= DW'(ic[i]) - DW'(ib[i]);
      end
    end
  end

  // Component products of the nine dot products.
  always_ff @(posedge clk) begin
    if (adv) begin
      g2 <= g1;
      for (int i = 0; i < 3; i++) begin
        pr2[D1][i]  <= ab1[i] * ap1[i];
        pr2[D2][i]  <= ac1[i] * ap1[i];
        pr2[D3][i]  <= ab1[i] * bp1[i];
        pr2[D4][i]  <= ac1[i] * bp1[i];
        pr2[D5][i]  <= ab1[i] * cp1[i];
        pr2[D6][i]  <= ac1[i] * cp1[i];
        pr2[EAB][i] <= ab1[i] * ab1[i];
        pr2[EAC][i] <= ac1[i] * ac1[i];
        pr2[EBC][i] <= bc1[i] * bc1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g3 <= g2;
      for (int k = 0; k < 9; k++) begin
        dt3[k] <= TW'(pr2[k][0]) + TW'(pr2[k][1]) + TW'(pr2[k][2]);
      end
    end
  end

  // Partial products of the six cross terms of the barycentric weights.
  always_ff @(posedge clk) begin
    if (adv) begin
      g4     <= g3;
      dt4    <= dt3;
      nbc4   <= dt3[D4] - dt3[D3];
      pp4[0] <= split_mul(dt3[D1], dt3[D4]);
      pp4[1] <= split_mul(dt3[D3], dt3[D2]);
      pp4[2] <= split_mul(dt3[D5], dt3[D2]);
      pp4[3] <= split_mul(dt3[D1], dt3[D6]);
      pp4[4] <= split_mul(dt3[D3], dt3[D6]);
      pp4[5] <= split_mul(dt3[D5], dt3[D4]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g5   <= g4;
      dt5  <= dt4;
      nbc5 <= nbc4;
      for (int k = 0; k < 6; k++) pw5[k] <= sum_pp(pp4[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g6   <= g5;
      dt6  <= dt5;
      nbc6 <= nbc5;
      vc6  <= pw5[0] - pw5[1];
      vb6  <= pw5[2] - pw5[3];
      va6  <= pw5[4] - pw5[5];
    end
  end

  // Region tests and segment clamp tests.
  always_ff @(posedge clk) begin
    if (adv) begin
      g7        <= g6;
      dt7       <= dt6;
      nbc7      <= nbc6;
      vb7       <= vb6;
      vc7       <= vc6;
      den7      <= va6 + vb6 + vc6;
      fl7.ca    <= (dt6[D1] <= 0) && (dt6[D2] <= 0);
      fl7.cb    <= (dt6[D3] >= 0) && (dt6[D4] <= dt6[D3]);
      fl7.cab   <= (vc6 <= 0) && (dt6[D1] >= 0) && (dt6[D3] <= 0);
      fl7.cc    <= (dt6[D6] >= 0) && (dt6[D5] <= dt6[D6]);
      fl7.cac   <= (vb6 <= 0) && (dt6[D2] >= 0) && (dt6[D6] <= 0);
      fl7.cbc   <= (va6 <= 0) && (dt6[D4] >= dt6[D3]) && (dt6[D5] >= dt6[D6]);
      fl7.lo_ab <= (dt6[EAB] == 0) || (dt6[D1] <= 0);
      fl7.hi_ab <= (dt6[D1] >= dt6[EAB]);
      fl7.lo_ac <= (dt6[EAC] == 0) || (dt6[D2] <= 0);
      fl7.hi_ac <= (dt6[D2] >= dt6[EAC]);
      fl7.lo_bc <= (dt6[EBC] == 0) || (nbc6 <= 0);
      fl7.hi_bc <= (nbc6 >= dt6[EBC]);
    end
  end

  always_comb begin
    job_next = '0;
    if (fl7.ca) begin
      job_next.pass   = 1'b1;
      job_next.pt     = g7.a;
      job_next.region = REG_A;
    end else if (fl7.cb) begin
      job_next.pass   = 1'b1;
      job_next.pt     = g7.b;
      job_next.region = REG_B;
    end else if (fl7.cab) begin
      job_next = seg_job(g7.a, g7.b, g7.ab, dt7[D1], dt7[EAB], fl7.lo_ab, fl7.hi_ab,
                         REG_AB);
    end else if (fl7.cc) begin
      job_next.pass   = 1'b1;
      job_next.pt     = g7.c;
      job_next.region = REG_C;
    end else if (fl7.cac) begin
      job_next = seg_job(g7.a, g7.c, g7.ac, dt7[D2], dt7[EAC], fl7.lo_ac, fl7.hi_ac,
                         REG_AC);
    end else if (fl7.cbc) begin
      job_next = seg_job(g7.b, g7.c, g7.bc, nbc7, dt7[EBC], fl7.lo_bc, fl7.hi_bc,
                         REG_BC);
    end else if (den7 < DEGEN_LIMIT) begin
      job_next = seg_job(g7.a, g7.b, g7.ab, dt7[D1], dt7[EAB], fl7.lo_ab, fl7.hi_ab,
                         REG_DEG);
    end else begin
      job_next.pass   = 1'b0;
      job_next.pt     = g7.a;
      job_next.m1     = g7.ab;
      job_next.k1     = vb7;
      job_next.m2     = g7.ac;
      job_next.k2     = vc7;
      job_next.den    = den7;
      job_next.region = REG_IN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) job <= job_next;
  end

endmodule

/* src/cpt_back.sv */
// Back end: forms the offset numerators, divides with rounding in a
// subtract-per-stage pipeline, adds the base point and saturates. Depends on cpt_pkg.
module cpt_back (
  input  logic          clk,
  input  logic          rst,
  input  cpt_pkg::job_t head,
  input  logic          head_valid,
  output logic          pop,
  cpt_rsp_if.source     rsp
);
  import cpt_pkg::*;

  localparam int PPW = DW + KCH + 1;
  localparam int NST = 6 + QB + 1;
  localparam int SW  = CW + 5;
  localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  typedef struct packed {
    logic               pass;
    region_t            region;
    logic [2:0][CW-1:0] pt;
    logic [VW-1:0]      den;
  } ctl_t;

  typedef struct packed {
    ctl_t               c;
    logic [VW:0]        d2;
    logic [2:0][NW-1:0] r;
    logic [2:0][QB-1:0] q;
    logic [2:0]         neg;
    logic [2:0]         ov;
  } div_t;

  function automatic logic signed [KCH:0] chunk(logic [VW-1:0] k, int n);
    logic [KW-1:0] kx;
    kx = {{(KW-VW){k[VW-1]}}, k};
    if (n == NK - 1) return {kx[KW-1], kx[KW-1 -: KCH]};
    return {1'b0, kx[n*KCH +: KCH]};
  endfunction

  logic           adv;
  logic [NST-1:0] vs;

  assign adv = !rsp.valid || rsp.ready;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs        <= '0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      vs        <= {vs[NST-2:0], pop};
      rsp.valid <= vs[NST-1];
    end
  end

  job_t                 j0;
  ctl_t                 c1, c2, c3, c4, c5;
  logic signed [PPW-1:0] p1a [3][NK], p1b [3][NK];
  logic signed [NW-1:0] s2a [3], s2b [3], n3 [3], t4 [3];
  logic [NW-1:0]        u5 [3];
  logic [2:0]           neg5;
  logic [VW:0]          d2_5;
  div_t                 dv [QB+1];

  always_ff @(posedge clk) begin
    if (adv) j0 <= head;
  end

  // Partial products of m1*k1 and m2*k2 over the chunks of k.
  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= '{pass: j0.pass, region: j0.region, pt: j0.pt, den: j0.den};
      for (int i = 0; i < 3; i++) begin
        for (int n = 0; n < NK; n++) begin
          p1a[i][n] <= $signed(j0.m1[i]) * chunk(j0.k1, n);
          p1b[i][n] <= $signed(j0.m2[i]) * chunk(j0.k2, n);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2 <= c1;
      for (int i = 0; i < 3; i++) begin
        s2a[i] <= (NW'(p1a[i][0])) + (NW'(p1a[i][1]) <<< KCH)
                + (NW'(p1a[i][2]) <<< (2*KCH)) + (NW'(p1a[i][3]) <<< (3*KCH))
                + (NW'(p1a[i][4]) <<< (4*KCH));
        s2b[i] <= (NW'(p1b[i][0])) + (NW'(p1b[i][1]) <<< KCH)
                + (NW'(p1b[i][2]) <<< (2*KCH)) + (NW'(p1b[i][3]) <<< (3*KCH))
                + (NW'(p1b[i][4]) <<< (4*KCH));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3 <= c2;
      for (int i = 0; i < 3; i++) n3[i] <= s2a[i] + s2b[i];
    end
  end

  // Rounding to nearest, ties upward: quotient of 2n+d by 2d.
  always_ff @(posedge clk) begin
    if (adv) begin
      c4 <= c3;
      for (int i = 0; i < 3; i++) t4[i] <= (n3[i] <<< 1) + $signed(NW'(c3.den));
    end
  end

  // A negative dividend is folded to a positive one that floors the same way.
  always_ff @(posedge clk) begin
    if (adv) begin
      c5   <= c4;
      d2_5 <= {c4.den, 1'b0};
      for (int i = 0; i < 3; i++) begin
        neg5[i] <= t4[i][NW-1];
        if (t4[i][NW-1]) begin
          u5[i] <= NW'(-t4[i]) + NW'({c4.den, 1'b0}) - NW'(1);
        end else begin
          u5[i] <= NW'(t4[i]);
        end
      end
    end
  end

  // A quotient too large for the kept bits saturates the result unless the job is a pass.
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].c   <= c5;
      dv[0].d2  <= d2_5;
      dv[0].neg <= neg5;
      dv[0].q   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv[0].r[i]  <= u5[i];
        dv[0].ov[i] <= (u5[i] >= (NW'(d2_5) << QB));
      end
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int K = QB - s;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[s].c   <= dv[s-1].c;
        dv[s].d2  <= dv[s-1].d2;
        dv[s].neg <= dv[s-1].neg;
        dv[s].ov  <= dv[s-1].ov;
        for (int i = 0; i < 3; i++) begin
          if (dv[s-1].r[i] >= (NW'(dv[s-1].d2) << K)) begin
            dv[s].r[i]    <= dv[s-1].r[i] - (NW'(dv[s-1].d2) << K);
            dv[s].q[i]    <= dv[s-1].q[i] | (QB'(1) << K);
          end else begin
            dv[s].r[i]    <= dv[s-1].r[i];
            dv[s].q[i]    <= dv[s-1].q[i];
          end
        end
      end
    end
  end

  logic signed [CW-1:0] res [3];
  logic signed [SW-1:0] qs [3];
  logic signed [SW-1:0] sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i]  = $signed(SW'(dv[QB].q[i]));
      sum[i] = SW'($signed(dv[QB].c.pt[i])) + (dv[QB].neg[i] ? -qs[i] : qs[i]);
      if (dv[QB].c.pass) begin
        res[i] = $signed(dv[QB].c.pt[i]);
      end else if (dv[QB].ov[i]) begin
        res[i] = dv[QB].neg[i] ? CW'(SMIN) : CW'(SMAX);
      end else if (sum[i] > SMAX) begin
        res[i] = CW'(SMAX);
      end else if (sum[i] < SMIN) begin
        res[i] = CW'(SMIN);
      end else begin
        res[i] = CW'(sum[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.near_x <= res[0];
      rsp.near_y <= res[1];
      rsp.near_z <= res[2];
      rsp.region <= dv[QB].c.region;
    end
  end

endmodule

/* src/closest_point_on_triangle.sv */
// Top level of the closest-point-on-triangle block.
// Depends on cpt_pkg, cpt_if, cpt_front, cpt_queue and cpt_back.

// The block takes one request per clock cycle unless a full queue stalls it,
// each carrying corners A, B, C and a query point P in signed Q16.16, and
// returns the nearest point of the triangle with a code for the region that
// holds P (a corner, an edge, the interior, or the fallback to edge AB for a
// degenerate triangle). Every unit is fully pipelined, so a new request can
// be taken in every cycle that no stall holds, and the sustained rate is one
// request per cycle while responses are taken. A request passes through the
// front end, the queue and the back end, whose longest part is the 35-stage
// subtract-and-compare quotient pipeline that rounds each offset. The front
// end classifies the request and the back end does the division; the short
// queue between them lets the front end keep taking requests while a
// response is held back, until the queue fills, and the registered response
// holds the whole back end while it waits to be taken. Edge and interior
// offsets are rounded to nearest with ties upward and the final sum saturates
// to the Q16.16 range.
module closest_point_on_triangle (
  input  logic      clk,
  input  logic      rst,
  cpt_req_if.sink   req,
  cpt_rsp_if.source rsp
);
  import cpt_pkg::*;

  job_t    job;
  job_t    head;
  logic    push;
  logic    pop;
  q_ctl_t  qctl;
  q_stat_t qstat;

  // Classification: dot products, barycentric weights and region choice.
  cpt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .qstat (qstat),
    .push  (push),
    .job   (job)
  );

  assign qctl.push = push;
  assign qctl.pop  = pop;

  // Decoupling queue; either side may stall without stopping the other until the queue is full or empty.
  cpt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (qctl),
    .wdata (job),
    .rdata (head),
    .stat  (qstat)
  );

  // Offset numerators, rounded division, base addition and saturation.
  cpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

/* sim/tb_closest_point_on_triangle.sv */
// Self-checking testbench for the closest-point-on-triangle block.
// Depends on cpt_pkg, the request and response interfaces, and the block itself.
module tb_closest_point_on_triangle;
  import cpt_pkg::*;

  typedef logic signed [255:0] big_t;
  typedef big_t vec3_t [3];
  typedef logic [31:0] pt3_t [3];

  typedef struct {
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] c [3];
    logic signed [31:0] p [3];
  } tri_req_t;

  typedef struct {
    logic [31:0] near [3];
    region_t     region;
  } near_rsp_t;

  localparam big_t DEGEN_BIG = 256'sd184467440737096;
  localparam int   N_DIRECTED = 15;
  localparam int   N_HOLD = 100;
  localparam int   N_RANDOM = 935;
  localparam int   N_CALM = 150;

  localparam logic [31:0] ZERO = 32'h0000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] TWO = 32'h0002_0000;
  localparam logic [31:0] THREE = 32'h0003_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] QUART = 32'h0000_4000;
  localparam logic [31:0] NEG1 = 32'hFFFF_0000;
  localparam logic [31:0] NEG5 = 32'hFFFB_0000;
  localparam logic [31:0] FIVE = 32'h0005_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  // Directed rows: corners A, B, C and P, x y z each.
  localparam logic [31:0] DIR_IN [N_DIRECTED][12] = '{
    '{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO},
    '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
    '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
    '{MINV, MINV, MINV, MAXV, MAXV, MAXV, ZERO, ZERO, ZERO, MINV, MINV, MINV},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, ONE, ZERO, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ONE, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, NEG5, NEG5, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, HALF, NEG1, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, NEG1, HALF, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, ONE, ONE, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, QUART, QUART, THREE},
    '{ZERO, ZERO, ZERO, TWO, ZERO, ZERO, ONE, ZERO, ZERO, ONE, ONE, ZERO},
    '{MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV},
    '{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, FIVE, ZERO},
    '{ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE, ZERO, 32'h0000_0001, 32'h0000_0003,
      32'hFFFF_FFFF}
  };
  // Where the answer is plain, the row names the corner that must come back;
  // a zero flag means the row goes through the predictor instead.
  localparam bit      DIR_KNOWN [N_DIRECTED] = '{1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam region_t DIR_CORNER [N_DIRECTED] = '{REG_A, REG_A, REG_A, REG_A, REG_B, REG_C,
      REG_A, REG_A, REG_A, REG_A, REG_A, REG_A, REG_A, REG_A, REG_A};

  logic clk;
  logic rst;
  cpt_req_if req ();
  cpt_rsp_if rsp ();

  closest_point_on_triangle dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  near_rsp_t pending_q [$];
  int        errors;
  bit        idle_on;
  bit        hold_req;

  // ---------------------------------------------------------------- predictor

  function automatic big_t dot3(vec3_t u, vec3_t v);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic logic [31:0] sat32(big_t x);
    if (x < -256'sd2147483648) return 32'h8000_0000;
    if (x > 256'sd2147483647) return 32'h7FFF_FFFF;
    return x[31:0];
  endfunction

  // Round n/d to nearest with ties upward; d is positive.
  function automatic big_t round_div(big_t n, big_t d);
    big_t d2;
    big_t t;
    d2 = d + d;
    t = n + n + d;
    if (t >= 0) return t / d2;
    return -((-t + d2 - 1) / d2);
  endfunction

  function automatic pt3_t to_pt(vec3_t q);
    pt3_t o;
    for (int i = 0; i < 3; i++) o[i] = q[i][31:0];
    return o;
  endfunction

  // Clamped projection of p onto segment s..e.
  function automatic pt3_t seg_near(vec3_t s, vec3_t e, vec3_t p);
    vec3_t se;
    vec3_t sp;
    big_t  den;
    big_t  num;
    pt3_t  o;
    for (int i = 0; i < 3; i++) begin
      se[i] = e[i] - s[i];
      sp[i] = p[i] - s[i];
    end
    den = dot3(se, se);
    num = dot3(sp, se);
    if (den == 0 || num <= 0) return to_pt(s);
    if (num >= den) return to_pt(e);
    for (int i = 0; i < 3; i++) o[i] = sat32(s[i] + round_div(se[i] * num, den));
    return o;
  endfunction

  function automatic near_rsp_t predict_near(tri_req_t r);
    vec3_t     a, b, c, p, ab, ac, ap, bp, cp;
    big_t      d1, d2, d3, d4, d5, d6, va, vb, vc, den;
    near_rsp_t o;
    for (int i = 0; i < 3; i++) begin
      a[i] = big_t'(r.a[i]);
      b[i] = big_t'(r.b[i]);
      c[i] = big_t'(r.c[i]);
      p[i] = big_t'(r.p[i]);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    if (d1 <= 0 && d2 <= 0) begin
      o.near = to_pt(a); o.region = REG_A; return o;
    end
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    if (d3 >= 0 && d4 <= d3) begin
      o.near = to_pt(b); o.region = REG_B; return o;
    end
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      o.near = seg_near(a, b, p); o.region = REG_AB; return o;
    end
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    if (d6 >= 0 && d5 <= d6) begin
      o.near = to_pt(c); o.region = REG_C; return o;
    end
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      o.near = seg_near(a, c, p); o.region = REG_AC; return o;
    end
    va = d3 * d6 - d5 * d4;
    if (va <= 0 && d4 >= d3 && d5 >= d6) begin
      o.near = seg_near(b, c, p); o.region = REG_BC; return o;
    end
    den = va + vb + vc;
    if (den < DEGEN_BIG) begin
      o.near = seg_near(a, b, p); o.region = REG_DEG; return o;
    end
    for (int i = 0; i < 3; i++) o.near[i] = sat32(a[i] + round_div(ab[i] * vb + ac[i] * vc, den));
    o.region = REG_IN;
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] small_coord(int unsigned span);
    return 32'($signed({1'b0, $urandom_range(0, 2 * span)}) - $signed({1'b0, span}));
  endfunction

  // Mostly small well-shaped triangles so every region is reached; some
  // full-range noise, collinear corners and repeated corners.
  function automatic tri_req_t random_tri();
    tri_req_t    t;
    int unsigned kind;
    int unsigned k;
    kind = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      if (kind < 10) begin
        t.a[i] = $urandom; t.b[i] = $urandom; t.c[i] = $urandom; t.p[i] = $urandom;
      end else begin
        t.a[i] = small_coord(32'h0004_0000);
        t.b[i] = small_coord(32'h0004_0000);
        t.c[i] = small_coord(32'h0004_0000);
        t.p[i] = small_coord(32'h0008_0000);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (kind >= 10 && kind < 18) t.c[i] = t.a[i] + (t.b[i] - t.a[i]) * k;
      else if (kind >= 18 && kind < 22) t.b[i] = t.a[i];
      else if (kind >= 22 && kind < 25) t.c[i] = t.b[i];
    end
    return t;
  endfunction

  task automatic send_request(tri_req_t t);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.a_x <= t.a[0]; req.a_y <= t.a[1]; req.a_z <= t.a[2];
    req.b_x <= t.b[0]; req.b_y <= t.b[1]; req.b_z <= t.b[2];
    req.c_x <= t.c[0]; req.c_y <= t.c[1]; req.c_z <= t.c[2];
    req.p_x <= t.p[0]; req.p_y <= t.p[1]; req.p_z <= t.p[2];
    // Ready is sampled at the falling edge before the rising edge that takes the request.
    do begin
      @(negedge clk);
      taken = req.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Response check at the falling edge; the values hold until the taking edge.
  always @(negedge clk) begin
    near_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: response with none outstanding: %h %h %h region %0d", $time,
                 rsp.near_x, rsp.near_y, rsp.near_z, rsp.region);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (rsp.near_x !== want.near[0]) begin
          $display("%0t: near_x expected %h actual %h", $time, want.near[0], rsp.near_x);
          errors++;
        end
        if (rsp.near_y !== want.near[1]) begin
          $display("%0t: near_y expected %h actual %h", $time, want.near[1], rsp.near_y);
          errors++;
        end
        if (rsp.near_z !== want.near[2]) begin
          $display("%0t: near_z expected %h actual %h", $time, want.near[2], rsp.near_z);
          errors++;
        end
        if (rsp.region !== want.region) begin
          $display("%0t: region expected %0d actual %0d", $time, want.region, rsp.region);
          errors++;
        end
      end
    end
  end

  initial begin
    #800000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tri_req_t  t;
    near_rsp_t e;
    errors = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.a_x <= '0; req.a_y <= '0; req.a_z <= '0;
    req.b_x <= '0; req.b_y <= '0; req.b_z <= '0;
    req.c_x <= '0; req.c_y <= '0; req.c_z <= '0;
    req.p_x <= '0; req.p_y <= '0; req.p_z <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: zero, extremes, each corner, edge, interior and fallback.
    for (int r = 0; r < N_DIRECTED; r++) begin
      for (int i = 0; i < 3; i++) begin
        t.a[i] = DIR_IN[r][i];
        t.b[i] = DIR_IN[r][3 + i];
        t.c[i] = DIR_IN[r][6 + i];
        t.p[i] = DIR_IN[r][9 + i];
      end
      if (DIR_KNOWN[r]) begin
        e.region = DIR_CORNER[r];
        for (int i = 0; i < 3; i++)
          e.near[i] = (e.region == REG_A) ? t.a[i] : (e.region == REG_B) ? t.b[i] : t.c[i];
      end else begin
        e = predict_near(t);
      end
      send_request(t);
      pending_q = {pending_q, e};
    end
    // Sender stands still until every response is back.
    wait_drained();

    // Long receiver hold-off while requests keep coming back to back; more
    // requests are offered than the pipeline and queue can hold.
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < N_HOLD; n++) begin
      t = random_tri();
      send_request(t);
      pending_q = {pending_q, predict_near(t)};
    end
    idle_on = 1'b1;

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) idle_on = 1'b0;
      t = random_tri();
      send_request(t);
      pending_q = {pending_q, predict_near(t)};
    end
    wait_drained();
    repeat (60) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* closest_point_on_triangle.f */
src/cpt_pkg.sv
src/cpt_if.sv
src/cpt_queue.sv
src/cpt_front.sv
src/cpt_back.sv
src/closest_point_on_triangle.sv
sim/tb_closest_point_on_triangle.sv
